// ===== rtl/fdcsv_pkg.sv =====
// fdcsv_pkg: types and constants of the fixed decimal csv parser
// no dependencies; used by the interfaces, the modules and the testbench
package fdcsv_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 19;
    localparam int unsigned COLUMN_W = 11;
    localparam int unsigned FPR_W    = 10;
    localparam int unsigned ROW_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES_PER_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FIRST_LINE  = 2'd2;

    // register reset values
    localparam logic [FPR_W-1:0] FPR_RESET       = 10'd1000;
    localparam logic [ROW_W-1:0] ROW_LIMIT_RESET = 16'd8000;

    // characters
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W:0]   CH_ZERO  = 9'h030;

    // parse phase
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_FIELD = 3'd1,
        PH_FIRST = 3'd2,
        PH_DOT   = 3'd3,
        PH_D1    = 3'd4,
        PH_D2    = 3'd5,
        PH_D3    = 3'd6
    } t_phase;

    typedef struct packed {
        logic [FPR_W-1:0] features_per_row;
        logic [ROW_W-1:0] row_limit;
        logic             skip_first_line;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COLUMN_W-1:0]       column;
        logic                      is_label;
        logic                      final_res;
    } t_result;

endpackage

// ===== rtl/fdcsv_in_if.sv =====
// fdcsv_in_if: input channel, one text byte per word
// depends on fdcsv_pkg
interface fdcsv_in_if;
    logic                          valid;
    logic                          ready;
    logic [fdcsv_pkg::BYTE_W-1:0]  byte_in;
    logic                          last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

// ===== rtl/fdcsv_out_if.sv =====
// fdcsv_out_if: result channel, one parsed field per word
// depends on fdcsv_pkg
interface fdcsv_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fdcsv_pkg::VALUE_W-1:0] value;
    logic [fdcsv_pkg::COLUMN_W-1:0]       column;
    logic                                 is_label;
    logic                                 final_res;

    modport source (output valid, output value, output column, output is_label,
                    output final_res, input ready);
    modport sink   (input valid, input value, input column, input is_label,
                    input final_res, output ready);
endinterface

// ===== rtl/fdcsv_cfg.sv =====
// fdcsv_cfg: configuration registers of the parser
// depends on fdcsv_pkg
module fdcsv_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fdcsv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdcsv_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output fdcsv_pkg::t_cfg                    o_cfg
);

    fdcsv_pkg::t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.features_per_row <= fdcsv_pkg::FPR_RESET;
            r_cfg.row_limit        <= fdcsv_pkg::ROW_LIMIT_RESET;
            r_cfg.skip_first_line  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fdcsv_pkg::CFG_FEATURES_PER_ROW: begin
                    r_cfg.features_per_row <= i_cfg_wdata[fdcsv_pkg::FPR_W-1:0];
                end
                fdcsv_pkg::CFG_ROW_LIMIT: begin
                    r_cfg.row_limit <= i_cfg_wdata[fdcsv_pkg::ROW_W-1:0];
                end
                fdcsv_pkg::CFG_SKIP_FIRST_LINE: begin
                    r_cfg.skip_first_line <= i_cfg_wdata[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/fdcsv_in_stage.sv =====
// fdcsv_in_stage: input register in front of the parse stage
// depends on fdcsv_pkg
module fdcsv_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fdcsv_pkg::t_in_word   i_word,
    output logic                  o_ready,
    output logic                  o_valid,
    output fdcsv_pkg::t_in_word   o_word,
    input  logic                  i_adv
);

    logic                r_valid;
    fdcsv_pkg::t_in_word r_word;

    // refill whenever the held word moves on or the stage is empty
    // no word is taken while reset is held
    assign o_ready = i_rst_n && (!r_valid || i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/fdcsv_core.sv =====
// fdcsv_core: parse state update and result register
// depends on fdcsv_pkg
module fdcsv_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fdcsv_pkg::t_cfg       i_cfg,
    input  logic                  i_valid,
    input  fdcsv_pkg::t_in_word   i_word,
    output logic                  o_adv,
    output logic                  o_res_valid,
    output fdcsv_pkg::t_result    o_res,
    input  logic                  i_res_ready
);

    fdcsv_pkg::t_phase                    r_phase, n_phase;
    logic                                 r_neg, n_neg;
    logic signed [fdcsv_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic [fdcsv_pkg::FPR_W-1:0]          r_col, n_col;
    logic [fdcsv_pkg::ROW_W-1:0]          r_row, n_row;
    logic                                 r_stop, n_stop;
    logic                                 r_out_valid;
    fdcsv_pkg::t_result                   r_res;

    logic                                 w_fire;
    logic [fdcsv_pkg::BYTE_W-1:0]         w_byte;
    logic signed [fdcsv_pkg::BYTE_W:0]    w_digit;
    logic signed [fdcsv_pkg::VALUE_W-1:0] w_digit_ext;
    logic signed [fdcsv_pkg::VALUE_W-1:0] w_mac;
    logic signed [fdcsv_pkg::VALUE_W-1:0] w_neg_mac;
    logic                                 w_start_ph;
    logic                                 w_plain;
    logic                                 w_take;
    logic                                 w_is_lab;
    logic [fdcsv_pkg::ROW_W-1:0]          w_row_inc;
    logic                                 w_fin;
    logic                                 w_res_valid;
    fdcsv_pkg::t_result                   w_res;

    // handshake: parse when the result register frees up
    assign o_adv  = !r_out_valid || i_res_ready;
    assign w_fire = i_valid && o_adv;
    assign w_byte = i_word.byte_in;

    // digit and multiply-accumulate by ten
    assign w_digit     = $signed({1'b0, w_byte}) - $signed(fdcsv_pkg::CH_ZERO);
    assign w_digit_ext = fdcsv_pkg::VALUE_W'(w_digit);
    assign w_mac       = (r_acc <<< 3) + (r_acc <<< 1) + w_digit_ext;
    assign w_neg_mac   = r_neg ? -w_mac : w_mac;

    // field start decode
    assign w_start_ph = (r_phase == fdcsv_pkg::PH_FIELD) ||
                        (r_phase == fdcsv_pkg::PH_START && !i_cfg.skip_first_line);
    assign w_plain    = (w_byte != fdcsv_pkg::CH_NUL) && (w_byte != fdcsv_pkg::CH_COMMA) &&
                        (w_byte != fdcsv_pkg::CH_LF) && (w_byte != fdcsv_pkg::CH_MINUS);
    assign w_take     = !r_stop && ((w_start_ph && w_plain) ||
                                    (r_phase == fdcsv_pkg::PH_FIRST));
    assign w_is_lab   = (r_col >= i_cfg.features_per_row);

    // row count and limit
    assign w_row_inc = r_row + 1'b1;
    assign w_fin     = (i_cfg.row_limit != '0) && (w_row_inc >= i_cfg.row_limit);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (!r_stop) begin
            unique case (r_phase)
                fdcsv_pkg::PH_START,
                fdcsv_pkg::PH_FIELD: begin
                    if (!w_start_ph) begin
                        if (w_byte == fdcsv_pkg::CH_LF) begin
                            n_phase = fdcsv_pkg::PH_FIELD;
                        end
                    end else if (w_byte == fdcsv_pkg::CH_MINUS) begin
                        n_phase = fdcsv_pkg::PH_FIRST;
                    end else if (w_take && !w_is_lab) begin
                        n_phase = fdcsv_pkg::PH_DOT;
                    end else begin
                        n_phase = fdcsv_pkg::PH_FIELD;
                    end
                end
                fdcsv_pkg::PH_FIRST: begin
                    n_phase = w_is_lab ? fdcsv_pkg::PH_FIELD : fdcsv_pkg::PH_DOT;
                end
                fdcsv_pkg::PH_DOT: n_phase = fdcsv_pkg::PH_D1;
                fdcsv_pkg::PH_D1:  n_phase = fdcsv_pkg::PH_D2;
                fdcsv_pkg::PH_D2:  n_phase = fdcsv_pkg::PH_D3;
                fdcsv_pkg::PH_D3:  n_phase = fdcsv_pkg::PH_FIELD;
                default:           n_phase = fdcsv_pkg::PH_FIELD;
            endcase
        end
    end

    // datapath, counters and result
    always_comb begin
        n_neg          = r_neg;
        n_acc          = r_acc;
        n_col          = r_col;
        n_row          = r_row;
        n_stop         = r_stop;
        w_res_valid    = 1'b0;
        w_res.value    = w_digit_ext;
        w_res.column   = {1'b0, r_col} + 1'b1;
        w_res.is_label = 1'b1;
        w_res.final_res = w_fin;
        if (!r_stop) begin
            // field start clears the sign, minus sets it, zero byte halts
            if (w_start_ph) begin
                n_neg = (w_byte == fdcsv_pkg::CH_MINUS);
                if (w_byte == fdcsv_pkg::CH_NUL) begin
                    n_stop = 1'b1;
                end
            end
            // first byte of a field: label or leading digit
            if (w_take) begin
                if (w_is_lab) begin
                    n_row       = w_row_inc;
                    n_col       = '0;
                    w_res_valid = 1'b1;
                    if (w_fin) begin
                        n_stop = 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                    n_acc = w_digit_ext;
                end
            end
            // remaining digits
            if (r_phase == fdcsv_pkg::PH_D1 || r_phase == fdcsv_pkg::PH_D2) begin
                n_acc = w_mac;
            end
            if (r_phase == fdcsv_pkg::PH_D3) begin
                n_acc           = '0;
                n_neg           = 1'b0;
                w_res_valid     = 1'b1;
                w_res.value     = w_neg_mac;
                w_res.column    = {1'b0, r_col};
                w_res.is_label  = 1'b0;
                w_res.final_res = 1'b0;
            end
            if (i_word.last_byte) begin
                n_stop = 1'b1;
            end
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fdcsv_pkg::PH_START;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_stop  <= 1'b0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_col   <= n_col;
            r_row   <= n_row;
            r_stop  <= n_stop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= w_fire && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/fixed_decimal_csv_parser.sv =====
// fixed_decimal_csv_parser: top level of the fixed decimal csv parser
// depends on fdcsv_pkg, fdcsv_in_if, fdcsv_out_if, fdcsv_cfg, fdcsv_in_stage, fdcsv_core
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    byte_in[7:0], last_byte
//  o_out     out  valid/ready    value[18:0] signed, column[10:0], is_label, final_res
//  i_cfg_*   in   i_cfg_we       i_cfg_idx[1:0], i_cfg_wdata[15:0]
//
// one byte per cycle sustained while o_out is not stalled; each result is registered
// the rate is set by the single parse stage between the input and result registers
// synchronous active-low reset clears parse state, counters and valid flags, config to defaults
// a stalled result holds in its register; the input register keeps taking one byte
// meanwhile, after which i_in.ready follows o_out.ready
module fixed_decimal_csv_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fdcsv_in_if.sink                          i_in,
    fdcsv_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [fdcsv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fdcsv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    fdcsv_pkg::t_cfg     w_cfg;
    fdcsv_pkg::t_in_word w_in_word;
    fdcsv_pkg::t_in_word w_stage_word;
    logic                w_stage_valid;
    logic                w_adv;
    logic                w_res_valid;
    fdcsv_pkg::t_result  w_res;

    assign w_in_word.byte_in   = i_in.byte_in;
    assign w_in_word.last_byte = i_in.last_byte;

    // configuration registers
    fdcsv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // input register
    fdcsv_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_word  (w_in_word),
        .o_ready (i_in.ready),
        .o_valid (w_stage_valid),
        .o_word  (w_stage_word),
        .i_adv   (w_adv)
    );

    // parse stage and result register
    fdcsv_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_stage_valid),
        .i_word      (w_stage_word),
        .o_adv       (w_adv),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (o_out.ready)
    );

    assign o_out.valid     = w_res_valid;
    assign o_out.value     = w_res.value;
    assign o_out.column    = w_res.column;
    assign o_out.is_label  = w_res.is_label;
    assign o_out.final_res = w_res.final_res;

endmodule

// ===== rtl/fdcsv_checker.sv =====
// fdcsv_checker: port-level assertions for the parser, bound to the top level
// depends on fdcsv_out_if and fixed_decimal_csv_parser
module fdcsv_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fdcsv_out_if.source  o_out
);

    // result register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // a stalled word keeps its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.value) &&
        $stable(o_out.column) && $stable(o_out.is_label) && $stable(o_out.final_res))
        else $error("stalled word changed");

    // only a label can hit the row limit
    a_final_on_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.final_res |-> o_out.is_label)
        else $error("final flag on a feature");

    // columns are one-based
    a_column_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.column != '0)
        else $error("zero column");

    // nothing follows the word that reached the row limit
    a_quiet_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.final_res |=> !o_out.valid)
        else $error("word after row limit");

endmodule

bind fixed_decimal_csv_parser fdcsv_checker u_fdcsv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_out   (o_out)
);

// ===== test/testbench.sv =====
// testbench: self-checking bench for the fixed decimal csv parser
// streams text bytes through the input channel and checks every parsed word
// depends on fdcsv_pkg, fdcsv_in_if, fdcsv_out_if and fixed_decimal_csv_parser
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fdcsv_pkg::*;

    localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;
    localparam int SETTLE_CYCLES = 4;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    fdcsv_in_if  in_if ();
    fdcsv_out_if out_if ();

    fixed_decimal_csv_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // bytes waiting to be sent and parsed fields still to come out
    t_in_word byte_q[$];
    t_result  field_q[$];
    int       err_count = 0;
    int       pushed    = 0;
    bit       zero_ok   = 1'b0;

    // shadow registers
    logic [FPR_W-1:0] cur_fpr   = FPR_RESET;
    logic [ROW_W-1:0] cur_limit = ROW_LIMIT_RESET;
    logic             cur_skip  = 1'b0;

    // shadow parse state
    t_phase           ps_phase   = PH_START;
    bit               ps_neg     = 1'b0;
    int               ps_acc     = 0;
    logic [FPR_W-1:0] ps_col     = '0;
    logic [ROW_W-1:0] ps_rows    = '0;
    bit               ps_stopped = 1'b0;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // leading byte of a field: a label once the row is full, else the units digit
    function automatic bit take_lead(input int d, output t_result r);
        r = '0;
        if (ps_col >= cur_fpr) begin
            r.value    = d[VALUE_W-1:0];
            r.column   = COLUMN_W'(ps_col) + 11'd1;
            r.is_label = 1'b1;
            ps_rows    = ps_rows + 1'b1;
            ps_col     = '0;
            ps_phase   = PH_FIELD;
            if (cur_limit != '0 && ps_rows >= cur_limit) begin
                r.final_res = 1'b1;
                ps_stopped  = 1'b1;
            end
            return 1'b1;
        end
        ps_col   = ps_col + 1'b1;
        ps_acc   = d;
        ps_phase = PH_DOT;
        return 1'b0;
    endfunction

    // advance the shadow parser by one byte; returns 1 with a parsed field
    function automatic bit parse_byte(input t_in_word w, output t_result r);
        int d;
        int v;
        bit got;
        d   = int'(w.byte_in) - int'(CH_ZERO);
        got = 1'b0;
        r   = '0;
        if (ps_stopped) return 1'b0;
        if (ps_phase == PH_START && cur_skip) begin
            if (w.byte_in == CH_LF) ps_phase = PH_FIELD;
        end else begin
            case (ps_phase)
                PH_START, PH_FIELD: begin
                    ps_phase = PH_FIELD;
                    ps_neg   = 1'b0;
                    if (w.byte_in == CH_NUL) begin
                        ps_stopped = 1'b1;
                    end else if (w.byte_in == CH_MINUS) begin
                        ps_neg   = 1'b1;
                        ps_phase = PH_FIRST;
                    end else if (w.byte_in != CH_COMMA && w.byte_in != CH_LF) begin
                        got = take_lead(d, r);
                    end
                end
                PH_FIRST: got = take_lead(d, r);
                PH_DOT:   ps_phase = PH_D1;
                PH_D1: begin
                    ps_acc   = ps_acc * 10 + d;
                    ps_phase = PH_D2;
                end
                PH_D2: begin
                    ps_acc   = ps_acc * 10 + d;
                    ps_phase = PH_D3;
                end
                default: begin
                    v = ps_acc * 10 + d;
                    if (ps_neg) v = -v;
                    ps_acc   = 0;
                    ps_neg   = 1'b0;
                    ps_phase = PH_FIELD;
                    r.value  = v[VALUE_W-1:0];
                    r.column = COLUMN_W'(ps_col);
                    got      = 1'b1;
                end
            endcase
        end
        if (w.last_byte) ps_stopped = 1'b1;
        return got;
    endfunction

    function automatic logic [BYTE_W-1:0] digit_char(input int n);
        return BYTE_W'(int'(CH_ZERO) + n);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_digit();
        if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(0, 255));
        return digit_char($urandom_range(0, 9));
    endfunction

    // queue one byte and its expected field; a zero byte is kept off field
    // starts until the stream is meant to end
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_in_word w;
        t_result  r;
        w.byte_in   = b;
        w.last_byte = last;
        if (b == CH_NUL && !zero_ok &&
            (ps_phase == PH_FIELD || (ps_phase == PH_START && !cur_skip)))
            w.byte_in = digit_char(1);
        byte_q = {byte_q, w};
        if (parse_byte(w, r)) field_q = {field_q, r};
        pushed++;
    endtask

    task automatic push_feature();
        if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS, 1'b0);
        push_byte(rand_digit(), 1'b0);
        push_byte(($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(0, 255)) : CH_DOT,
                  1'b0);
        repeat (3) push_byte(rand_digit(), 1'b0);
        case ($urandom_range(0, 7))
            0: ;
            1: begin
                push_byte(CH_COMMA, 1'b0);
                push_byte(CH_COMMA, 1'b0);
            end
            2: push_byte(CH_LF, 1'b0);
            default: push_byte(CH_COMMA, 1'b0);
        endcase
    endtask

    task automatic push_label();
        if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS, 1'b0);
        if ($urandom_range(0, 7) == 0) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        else push_byte(digit_char($urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 3) != 0) push_byte(CH_LF, 1'b0);
    endtask

    // features up to the row width, at most 16 per call, then the label once the row is full
    task automatic push_row();
        int n;
        n = 0;
        while (ps_col < cur_fpr && n < 16 && !ps_stopped) begin
            push_feature();
            n++;
        end
        if (ps_col >= cur_fpr && !ps_stopped) push_label();
    endtask

    // short runs of separators, signs, digits and arbitrary bytes
    task automatic push_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0: push_byte(CH_COMMA, 1'b0);
                1: push_byte(CH_MINUS, 1'b0);
                2: push_byte(digit_char($urandom_range(0, 9)), 1'b0);
                default: push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || field_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_DATA_W'(data);
        case (idx)
            CFG_FEATURES_PER_ROW: cur_fpr   = FPR_W'(data);
            CFG_ROW_LIMIT:        cur_limit = ROW_W'(data);
            CFG_SKIP_FIRST_LINE:  cur_skip  = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int unsigned fpr, input int unsigned limit,
                              input int unsigned skip);
        write_reg(CFG_FEATURES_PER_ROW, fpr);
        write_reg(CFG_ROW_LIMIT, limit);
        write_reg(CFG_SKIP_FIRST_LINE, skip);
    endtask

    // sender: bursts of random length separated by random gaps
    int in_burst = 0;
    int in_gap   = 0;
    bit in_took  = 1'b0;

    always @(posedge i_clk) begin
        in_took = i_rst_n && in_if.valid && in_if.ready;
        if (in_took) void'(byte_q.pop_front());
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!(in_if.valid && !in_took)) begin
            if (in_burst == 0) begin
                in_burst = $urandom_range(1, 40);
                in_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (in_gap != 0) begin
                in_if.valid <= 1'b0;
                in_gap--;
            end else if (byte_q.size() != 0) begin
                in_if.valid     <= 1'b1;
                in_if.byte_in   <= byte_q[0].byte_in;
                in_if.last_byte <= byte_q[0].last_byte;
                in_burst--;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches between random modes
    int          rx_mode = 0;
    int          rx_left = 0;
    logic [1:0]  rx_tick = '0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(4, 64);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= 1'($urandom_range(0, 1));
            2: out_if.ready <= ($urandom_range(0, 3) == 0);
            default: out_if.ready <= (rx_tick != 2'd3);
        endcase
    end

    // compare each result word with the oldest expected field
    always @(posedge i_clk) begin : check_fields
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (field_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word value %0d column %0d",
                                          out_if.value, out_if.column));
            end else begin
                want = field_q.pop_front();
                if (out_if.value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d",
                                              out_if.value, want.value));
                if (out_if.column !== want.column)
                    report_mismatch($sformatf("column %0d, want %0d",
                                              out_if.column, want.column));
                if (out_if.is_label !== want.is_label)
                    report_mismatch($sformatf("is_label %b, want %b",
                                              out_if.is_label, want.is_label));
                if (out_if.final_res !== want.final_res)
                    report_mismatch($sformatf("final_res %b, want %b",
                                              out_if.final_res, want.final_res));
            end
        end
    end

    // stimulus
    initial begin
        int k;
        int target;
        int stop_kind;
        in_if.valid     = 1'b0;
        in_if.byte_in   = '0;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // header line with a zero byte is skipped
        set_config(2, 0, 1);
        push_byte(8'h61, 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_byte(CH_MINUS, 1'b0);
        push_byte(CH_LF, 1'b0);
        // largest positive feature from non-digit bytes
        push_byte(8'hFF, 1'b0);
        push_byte(CH_DOT, 1'b0);
        repeat (3) push_byte(8'hFF, 1'b0);
        push_byte(CH_COMMA, 1'b0);
        // zero after minus taken as digits
        push_byte(CH_MINUS, 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_byte(CH_DOT, 1'b0);
        repeat (3) push_byte(CH_NUL, 1'b0);
        push_byte(CH_COMMA, 1'b0);
        // minus before label is ignored
        push_byte(CH_MINUS, 1'b0);
        push_byte(digit_char(7), 1'b0);
        push_byte(CH_LF, 1'b0);
        // row left open with one feature
        push_byte(CH_MINUS, 1'b0);
        push_byte(digit_char(9), 1'b0);
        push_byte(CH_DOT, 1'b0);
        repeat (3) push_byte(digit_char(9), 1'b0);
        wait_idle();

        // row width lowered below the column count: every field is a label
        set_config(0, 16'hFFFF, 0);
        push_byte(digit_char(5), 1'b0);
        push_byte(CH_COMMA, 1'b0);
        push_byte(digit_char(3), 1'b0);

        // random phases, each with its own register settings
        for (k = 0; k < 7; k++) begin
            wait_idle();
            case (k)
                0: write_reg(CFG_FEATURES_PER_ROW, 1023);
                1: write_reg(CFG_FEATURES_PER_ROW, 1);
                default: begin
                    case ($urandom_range(0, 5))
                        0: write_reg(CFG_FEATURES_PER_ROW, 0);
                        1: write_reg(CFG_FEATURES_PER_ROW, $urandom_range(9, 40));
                        default: write_reg(CFG_FEATURES_PER_ROW, $urandom_range(1, 8));
                    endcase
                end
            endcase
            case ($urandom_range(0, 2))
                0: write_reg(CFG_ROW_LIMIT, 0);
                1: write_reg(CFG_ROW_LIMIT, 65535);
                default: write_reg(CFG_ROW_LIMIT, $urandom_range(20000, 65534));
            endcase
            write_reg(CFG_SKIP_FIRST_LINE, $urandom_range(0, 1));
            target = pushed + ((k == 0) ? 60 : 150);
            while (pushed < target) begin
                if ($urandom_range(0, 6) == 0) push_noise();
                else push_row();
            end
        end

        // end of stream: row limit, zero at a field start, or last byte mid-field
        wait_idle();
        stop_kind = $urandom_range(0, 2);
        if (stop_kind == 0) begin
            set_config($urandom_range(1, 4), int'(ps_rows) + $urandom_range(1, 3), 0);
            while (!ps_stopped) push_row();
        end else begin
            while (ps_phase != PH_FIELD) push_byte(digit_char(1), 1'b0);
            if (stop_kind == 1) begin
                zero_ok = 1'b1;
                push_byte(CH_NUL, 1'b0);
            end else begin
                push_byte(CH_MINUS, 1'b0);
                push_byte(digit_char(3), 1'b0);
                push_byte(CH_DOT, 1'b0);
                push_byte(digit_char(1), 1'b1);
            end
        end

        // everything after the stop is ignored
        zero_ok = 1'b1;
        push_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        repeat (8) push_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (err_count == 0 && field_q.size() == 0) begin
            $display("[fixed_decimal_csv_parser] OK");
        end else begin
            $display("[fixed_decimal_csv_parser] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("[fixed_decimal_csv_parser] ERROR");
        $finish;
    end

endmodule
